// ----- design/ldp_pkg.sv -----
package ldp_pkg;

    // Characters of the expression grammar
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

    // Dimension name codes
    localparam logic [3:0] NAME_N = 4'd0;
    localparam logic [3:0] NAME_C = 4'd1;
    localparam logic [3:0] NAME_H = 4'd2;
    localparam logic [3:0] NAME_W = 4'd3;
    localparam logic [3:0] NAME_G = 4'd4;
    localparam logic [3:0] NAME_K = 4'd5;
    localparam logic [3:0] NAME_R = 4'd6;
    localparam logic [3:0] NAME_S = 4'd7;
    localparam logic [3:0] NAME_P = 4'd8;
    localparam logic [3:0] NAME_Q = 4'd9;

    // Result field widths
    localparam int FIELD_WIDTH = 32;
    localparam int M_TDATA_WIDTH = 72;

    // Decoded character class
    typedef struct packed {
        logic       is_upper;
        logic       name_hit;
        logic [3:0] name_idx;
        logic       is_slash;
        logic       is_percent;
        logic       is_digit;
        logic [3:0] digit;
    } char_class_t;

endpackage

// ----- design/ldp_classify.sv -----
module ldp_classify (
    input  logic [7:0]                 char_code,
    output ldp_pkg::char_class_t       char_class
);

    logic [7:0] digit_offset;

    assign digit_offset = char_code - ldp_pkg::CHAR_DIGIT_0;

    // Sort the character into the grammar's classes
    always_comb begin
        char_class            = '0;
        char_class.is_upper   = (char_code >= ldp_pkg::CHAR_UPPER_A) &&
                                (char_code <= ldp_pkg::CHAR_UPPER_Z);
        char_class.is_slash   = (char_code == ldp_pkg::CHAR_SLASH);
        char_class.is_percent = (char_code == ldp_pkg::CHAR_PERCENT);
        char_class.is_digit   = (char_code >= ldp_pkg::CHAR_DIGIT_0) &&
                                (char_code <= ldp_pkg::CHAR_DIGIT_9);
        char_class.digit      = digit_offset[3:0];
        char_class.name_hit   = 1'b1;
        unique case (char_code)
            8'h4E:   char_class.name_idx = ldp_pkg::NAME_N;
            8'h43:   char_class.name_idx = ldp_pkg::NAME_C;
            8'h48:   char_class.name_idx = ldp_pkg::NAME_H;
            8'h57:   char_class.name_idx = ldp_pkg::NAME_W;
            8'h47:   char_class.name_idx = ldp_pkg::NAME_G;
            8'h4B:   char_class.name_idx = ldp_pkg::NAME_K;
            8'h52:   char_class.name_idx = ldp_pkg::NAME_R;
            8'h53:   char_class.name_idx = ldp_pkg::NAME_S;
            8'h50:   char_class.name_idx = ldp_pkg::NAME_P;
            8'h51:   char_class.name_idx = ldp_pkg::NAME_Q;
            default: begin
                char_class.name_idx = ldp_pkg::NAME_N;
                char_class.name_hit = 1'b0;
            end
        endcase
    end

endmodule

// ----- design/layout_dimension_parser_core.sv -----
// The result register, loaded as the last character advances, drives m_axis.
// Throughput: one character per cycle; the parse state is updated once per character
// by a single pass of logic between the input register and the result register. A last
// character waits in the input register while an untaken result holds the result register.
// Reset: aresetn is synchronous, active low, and clears the parse state and the valid
// flags of the input and result registers; the block takes characters right after reset.
module layout_dimension_parser_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] char_code
    input  logic [7:0]                        s_axis_tdata,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [3:0] name_index, [35:4] stride, [36] extent_known, [68:37] extent, [71:69] zero
    output logic [ldp_pkg::M_TDATA_WIDTH-1:0] m_axis_tdata,
    // [0] error
    output logic                              m_axis_tuser
);

    localparam int FW = ldp_pkg::FIELD_WIDTH;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_last_reg;

    // Parse state
    logic                   name_seen_reg,     name_seen_next;
    logic [3:0]             letter_index_reg,  letter_index_next;
    logic                   stride_seen_reg,   stride_seen_next;
    logic                   extent_seen_reg,   extent_seen_next;
    logic                   slash_pending_reg, slash_pending_next;
    logic [VALUE_WIDTH-1:0] stride_acc_reg,    stride_acc_next;
    logic [VALUE_WIDTH-1:0] extent_acc_reg,    extent_acc_next;
    logic                   failed_reg,        failed_next;

    // Result register
    logic                            out_valid_reg;
    logic [ldp_pkg::M_TDATA_WIDTH-1:0] out_data_reg, out_data_next;
    logic                            out_error_reg, out_error_next;

    ldp_pkg::char_class_t   char_class;
    logic                   out_free;
    logic                   advance;
    logic [VALUE_WIDTH-1:0] digit_ext;
    logic [VALUE_WIDTH-1:0] stride_x10;
    logic [VALUE_WIDTH-1:0] extent_x10;
    logic [FW-1:0]          stride_field;
    logic [FW-1:0]          extent_field;
    logic                   result_error;

    ldp_classify u_classify (
        .char_code  (in_char_reg),
        .char_class (char_class)
    );

    // Move a character on unless it ends an expression and the result slot is full
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || advance;

    // Shift in one decimal digit
    assign digit_ext  = VALUE_WIDTH'(char_class.digit);
    assign stride_x10 = {stride_acc_reg[VALUE_WIDTH-4:0], 3'b000}
                      + {stride_acc_reg[VALUE_WIDTH-2:0], 1'b0} + digit_ext;
    assign extent_x10 = {extent_acc_reg[VALUE_WIDTH-4:0], 3'b000}
                      + {extent_acc_reg[VALUE_WIDTH-2:0], 1'b0} + digit_ext;

    // Next parse state for the character in the input register
    always_comb begin
        name_seen_next     = name_seen_reg;
        letter_index_next  = letter_index_reg;
        stride_seen_next   = stride_seen_reg;
        extent_seen_next   = extent_seen_reg;
        slash_pending_next = slash_pending_reg;
        stride_acc_next    = stride_acc_reg;
        extent_acc_next    = extent_acc_reg;
        failed_next        = failed_reg;
        if (!failed_reg) begin
            priority if (slash_pending_reg) begin
                slash_pending_next = 1'b0;
                if (!char_class.is_slash || !name_seen_reg || stride_seen_reg
                        || extent_seen_reg) begin
                    failed_next = 1'b1;
                end else begin
                    stride_seen_next = 1'b1;
                    stride_acc_next  = '0;
                end
            end else if (char_class.is_upper) begin
                if (name_seen_reg || !char_class.name_hit) begin
                    failed_next = 1'b1;
                end else begin
                    name_seen_next    = 1'b1;
                    letter_index_next = char_class.name_idx;
                end
            end else if (char_class.is_slash) begin
                slash_pending_next = 1'b1;
            end else if (char_class.is_percent) begin
                if (!name_seen_reg || extent_seen_reg) begin
                    failed_next = 1'b1;
                end else begin
                    extent_seen_next = 1'b1;
                    extent_acc_next  = '0;
                end
            end else if (char_class.is_digit) begin
                priority if (!name_seen_reg) begin
                    failed_next = 1'b1;
                end else if (extent_seen_reg) begin
                    extent_acc_next = extent_x10;
                end else if (stride_seen_reg) begin
                    stride_acc_next = stride_x10;
                end else begin
                    // drop digits that follow the name
                    failed_next = failed_reg;
                end
            end else begin
                failed_next = 1'b1;
            end
        end
    end

    // Take the low field bits of the accumulators, or zero-extend them when they are narrower
    generate
        if (VALUE_WIDTH >= FW) begin : g_field_trunc
            assign stride_field = stride_acc_next[FW-1:0];
            assign extent_field = extent_acc_next[FW-1:0];
        end else begin : g_field_ext
            assign stride_field = FW'(stride_acc_next);
            assign extent_field = FW'(extent_acc_next);
        end
    endgenerate

    // Form the result of an expression
    assign result_error = failed_next || slash_pending_next || !name_seen_next;

    always_comb begin
        out_error_next = result_error;
        out_data_next  = '0;
        if (!result_error) begin
            out_data_next[3:0]   = letter_index_next;
            out_data_next[35:4]  = stride_seen_next ? stride_field : FW'(1);
            out_data_next[36]    = extent_seen_next;
            out_data_next[68:37] = extent_seen_next ? extent_field : '0;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // Parse state: update per character, clear after the last one
    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && in_last_reg)) begin
            name_seen_reg     <= 1'b0;
            letter_index_reg  <= '0;
            stride_seen_reg   <= 1'b0;
            extent_seen_reg   <= 1'b0;
            slash_pending_reg <= 1'b0;
            stride_acc_reg    <= '0;
            extent_acc_reg    <= '0;
            failed_reg        <= 1'b0;
        end else if (advance) begin
            name_seen_reg     <= name_seen_next;
            letter_index_reg  <= letter_index_next;
            stride_seen_reg   <= stride_seen_next;
            extent_seen_reg   <= extent_seen_next;
            slash_pending_reg <= slash_pending_next;
            stride_acc_reg    <= stride_acc_next;
            extent_acc_reg    <= extent_acc_next;
            failed_reg        <= failed_next;
        end
    end

    // Result register: load on the last character, hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && in_last_reg) begin
            out_data_reg  <= out_data_next;
            out_error_reg <= out_error_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_error_reg;

endmodule

// ----- verif/layout_dimension_parser_core_tb.sv -----
`timescale 1ns / 1ps

module layout_dimension_parser_core_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 6;
    localparam int REPORT_LIMIT = 10;

    localparam logic [7:0] NAME_CHARS [10] = '{"N", "C", "H", "W", "G", "K", "R", "S", "P", "Q"};

    typedef struct packed {
        logic        error;
        logic [3:0]  name_index;
        logic [31:0] stride;
        logic        extent_known;
        logic [31:0] extent;
    } dim_result_t;

    logic                              aclk = 1'b0;
    logic                              aresetn;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    // [7:0] char_code
    logic [7:0]                        s_axis_tdata;
    logic                              s_axis_tlast;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    // [3:0] name_index, [35:4] stride, [36] extent_known, [68:37] extent, [71:69] zero
    logic [ldp_pkg::M_TDATA_WIDTH-1:0] m_axis_tdata;
    // [0] error
    logic                              m_axis_tuser;

    // Parser state as the testbench tracks it
    logic        pr_name_seen     = 1'b0;
    logic [3:0]  pr_letter        = '0;
    logic        pr_stride_seen   = 1'b0;
    logic        pr_extent_seen   = 1'b0;
    logic        pr_slash_pending = 1'b0;
    logic [31:0] pr_stride_acc    = '0;
    logic [31:0] pr_extent_acc    = '0;
    logic        pr_failed        = 1'b0;

    dim_result_t pending_dims[$];
    logic [7:0]  expr_buf[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int stall_left     = 0;

    layout_dimension_parser_core #(
        .VALUE_WIDTH(32)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Drive result ready: long hold-off first, otherwise random stalls
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void note_failure(input string msg);
        if (mismatch_count < REPORT_LIMIT) begin
            $display("%s", msg);
        end
        mismatch_count++;
    endfunction

    // Advance the tracked parse state by one character
    function automatic void step_parser(input logic [7:0] c);
        logic [3:0] idx;
        logic       hit;
        logic [3:0] digit;
        idx   = '0;
        hit   = 1'b1;
        digit = 4'(c - ldp_pkg::CHAR_DIGIT_0);
        if (pr_slash_pending) begin
            pr_slash_pending = 1'b0;
            if (c != ldp_pkg::CHAR_SLASH || !pr_name_seen || pr_stride_seen
                    || pr_extent_seen) begin
                pr_failed = 1'b1;
            end else begin
                pr_stride_seen = 1'b1;
                pr_stride_acc  = '0;
            end
        end else if (c >= ldp_pkg::CHAR_UPPER_A && c <= ldp_pkg::CHAR_UPPER_Z) begin
            unique case (c)
                "N": idx = ldp_pkg::NAME_N;
                "C": idx = ldp_pkg::NAME_C;
                "H": idx = ldp_pkg::NAME_H;
                "W": idx = ldp_pkg::NAME_W;
                "G": idx = ldp_pkg::NAME_G;
                "K": idx = ldp_pkg::NAME_K;
                "R": idx = ldp_pkg::NAME_R;
                "S": idx = ldp_pkg::NAME_S;
                "P": idx = ldp_pkg::NAME_P;
                "Q": idx = ldp_pkg::NAME_Q;
                default: hit = 1'b0;
            endcase
            if (pr_name_seen || !hit) begin
                pr_failed = 1'b1;
            end else begin
                pr_name_seen = 1'b1;
                pr_letter    = idx;
            end
        end else if (c == ldp_pkg::CHAR_SLASH) begin
            pr_slash_pending = 1'b1;
        end else if (c == ldp_pkg::CHAR_PERCENT) begin
            if (!pr_name_seen || pr_extent_seen) begin
                pr_failed = 1'b1;
            end else begin
                pr_extent_seen = 1'b1;
                pr_extent_acc  = '0;
            end
        end else if (c >= ldp_pkg::CHAR_DIGIT_0 && c <= ldp_pkg::CHAR_DIGIT_9) begin
            // digits right after the name are dropped
            if (!pr_name_seen) begin
                pr_failed = 1'b1;
            end else if (pr_extent_seen) begin
                pr_extent_acc = pr_extent_acc * 32'd10 + 32'(digit);
            end else if (pr_stride_seen) begin
                pr_stride_acc = pr_stride_acc * 32'd10 + 32'(digit);
            end
        end else begin
            pr_failed = 1'b1;
        end
    endfunction

    // Track one accepted character; on the last one queue the parsed dimension
    function automatic void predict_char(input logic [7:0] c, input logic last);
        dim_result_t r;
        r = '0;
        if (!pr_failed) begin
            step_parser(c);
        end
        if (last) begin
            if (pr_failed || pr_slash_pending || !pr_name_seen) begin
                r.error = 1'b1;
            end else begin
                r.name_index   = pr_letter;
                r.stride       = pr_stride_seen ? pr_stride_acc : 32'd1;
                r.extent_known = pr_extent_seen;
                r.extent       = pr_extent_seen ? pr_extent_acc : 32'd0;
            end
            pending_dims.push_back(r);
            pr_name_seen     = 1'b0;
            pr_letter        = '0;
            pr_stride_seen   = 1'b0;
            pr_extent_seen   = 1'b0;
            pr_slash_pending = 1'b0;
            pr_stride_acc    = '0;
            pr_extent_acc    = '0;
            pr_failed        = 1'b0;
        end
    endfunction

    // Compare each result with the oldest queued dimension
    always @(posedge aclk) begin
        dim_result_t got;
        dim_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.error        = m_axis_tuser;
            got.name_index   = m_axis_tdata[3:0];
            got.stride       = m_axis_tdata[35:4];
            got.extent_known = m_axis_tdata[36];
            got.extent       = m_axis_tdata[68:37];
            if (pending_dims.size() == 0) begin
                note_failure($sformatf(
                    "unexpected result err=%0b name=%0d stride=%0d ek=%0b ext=%0d",
                    got.error, got.name_index, got.stride, got.extent_known, got.extent));
            end else begin
                want = pending_dims.pop_front();
                if (got !== want || m_axis_tdata[71:69] !== 3'b000) begin
                    note_failure({
                        $sformatf("mismatch: want err=%0b name=%0d stride=%0d ek=%0b ext=%0d",
                            want.error, want.name_index, want.stride, want.extent_known,
                            want.extent),
                        $sformatf(", got err=%0b name=%0d stride=%0d ek=%0b ext=%0d pad=%0h",
                            got.error, got.name_index, got.stride, got.extent_known,
                            got.extent, m_axis_tdata[71:69])});
                end
            end
        end
    end

    // Offer one character, with random idle cycles ahead of it
    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready) begin
            @(posedge aclk);
        end
        predict_char(c, last);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], i == s.len() - 1);
        end
    endtask

    // Hold the sender until every result is back, then let the pipeline settle
    task automatic wait_drained();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (pending_dims.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic int pick_digit_count();
        if ($urandom_range(9) == 0) begin
            return $urandom_range(10, 12);
        end
        return $urandom_range(0, 3);
    endfunction

    task automatic add_digits(input int n);
        repeat (n) expr_buf.push_back(ldp_pkg::CHAR_DIGIT_0 + 8'($urandom_range(9)));
    endtask

    // Build one expression: mostly well-formed, some damaged, some pure noise
    task automatic build_expr();
        int         kind;
        logic [7:0] junk;
        expr_buf.delete();
        kind = $urandom_range(99);
        if (kind < 10) begin
            repeat ($urandom_range(1, 4)) expr_buf.push_back(8'($urandom_range(255)));
        end else begin
            expr_buf.push_back(NAME_CHARS[$urandom_range(9)]);
            if ($urandom_range(3) == 0) begin
                add_digits($urandom_range(1, 2));
            end
            if ($urandom_range(1) == 1) begin
                expr_buf.push_back(ldp_pkg::CHAR_SLASH);
                expr_buf.push_back(ldp_pkg::CHAR_SLASH);
                add_digits(pick_digit_count());
            end
            if ($urandom_range(1) == 1) begin
                expr_buf.push_back(ldp_pkg::CHAR_PERCENT);
                add_digits(pick_digit_count());
            end
            // damage a share of them
            if (kind < 30) begin
                case ($urandom_range(4))
                    0: junk = 8'($urandom_range(255));
                    1: junk = ldp_pkg::CHAR_SLASH;
                    2: junk = ldp_pkg::CHAR_PERCENT;
                    3: junk = 8'($urandom_range(ldp_pkg::CHAR_UPPER_A, ldp_pkg::CHAR_UPPER_Z));
                    default: junk = ldp_pkg::CHAR_DIGIT_0 + 8'($urandom_range(9));
                endcase
                expr_buf.insert($urandom_range(expr_buf.size()), junk);
                if ($urandom_range(3) == 0) begin
                    expr_buf.delete($urandom_range(expr_buf.size() - 1));
                end
            end
        end
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_text("N");
        send_text("C//4%8");
        send_text("Q%");
        send_text("H//");
        send_text("W/");
        send_text("x");
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        send_text("5");
        send_text("NC");
        send_text("A");
        send_text("P%//");
        send_text("G9");
        wait_drained();
    endtask

    task automatic test_random(input int idle_pct, input int stall_pct, input int char_budget);
        int chars_sent;
        chars_sent     = 0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (chars_sent < char_budget) begin
            build_expr();
            for (int i = 0; i < expr_buf.size(); i++) begin
                send_char(expr_buf[i], i == expr_buf.size() - 1);
            end
            chars_sent += expr_buf.size();
        end
        wait_drained();
    endtask

    // Block the result side for a long stretch while requests keep coming
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge aclk);
        stall_left = 200;
        repeat (24) begin
            send_char(NAME_CHARS[$urandom_range(9)], 1'b1);
        end
        send_text("K//12%7");
        wait_drained();
    endtask

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random(0, 0, 250);
        test_random(54, 0, 250);
        test_random(0, 54, 250);
        test_backpressure();
        test_random(17, 17, 250);

        if (pending_dims.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", pending_dims.size()));
        end
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
